// File: rtl/elin_pkg.sv
// Shared types and constants for the encoder LUT linearizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package elin_pkg;

    localparam int ANGLE_W       = 16;
    localparam int TABLE_INDEX_W = 9;
    localparam int LUT_SIZE_W    = 9;
    localparam int THRESHOLD_W   = 15;
    localparam int CFG_DATA_W    = 15;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LUT_SIZE_W-1:0]  LUT_SIZE_RESET        = 9'd256;
    localparam logic [THRESHOLD_W-1:0] SPIKE_THRESHOLD_RESET = 15'd500;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

    typedef enum logic [0:0] {
        CFG_LUT_SIZE        = 1'b0,
        CFG_SPIKE_THRESHOLD = 1'b1
    } elin_cfg_index_t;

    typedef struct packed {
        logic                     mode;
        logic [ANGLE_W-1:0]       raw_angle;
        logic [TABLE_INDEX_W-1:0] table_index;
        logic [ANGLE_W-1:0]       table_value;
    } elin_in_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] calibrated_angle;
        logic               spike_rejected;
    } elin_out_t;

    // Classified job handed from the front end to the back end
    typedef struct packed {
        logic                     is_write;
        logic                     spike;
        logic [ANGLE_W-1:0]       raw_angle;
        logic [TABLE_INDEX_W-1:0] table_index;
        logic [ANGLE_W-1:0]       table_value;
    } elin_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } elin_qstat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_PROD,
        BK_SUM
    } elin_back_state_t;

endpackage

`default_nettype wire

// File: rtl/elin_front.sv
// Front end: accepts items, keeps the sample history and flags spikes.
// Depends on elin_pkg.
`default_nettype none

module elin_front (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               push,
    input  elin_pkg::elin_in_t                item,
    input  wire  [elin_pkg::THRESHOLD_W-1:0]  spike_threshold,
    input  elin_pkg::elin_qstat_t             qstat,
    output logic                              q_push,
    output elin_pkg::elin_job_t               q_job
);
    import elin_pkg::*;

    logic [ANGLE_W-1:0] prev_reg,      prev_next;
    logic [ANGLE_W-1:0] prev_prev_reg, prev_prev_next;
    logic               primed_reg,    primed_next;

    logic [ANGLE_W-1:0] recent, older;
    logic               far_recent, far_older;

    // Wrapped distance magnitude (up to 32768) against the threshold
    function automatic logic far_apart(input logic [ANGLE_W-1:0] x,
                                       input logic [ANGLE_W-1:0] y,
                                       input logic [THRESHOLD_W-1:0] thr);
        logic [ANGLE_W-1:0] d;
        logic [ANGLE_W:0]   mag;
        begin
            d   = x - y;
            mag = d[ANGLE_W-1] ? ((ANGLE_W+1)'(1 << ANGLE_W) - {1'b0, d}) : {1'b0, d};
            far_apart = mag > (ANGLE_W+1)'(thr);
        end
    endfunction

    always_comb
    begin
        // first sample after reset stands in for its own history
        recent     = primed_reg ? prev_reg      : item.raw_angle;
        older      = primed_reg ? prev_prev_reg : item.raw_angle;
        far_recent = far_apart(item.raw_angle, recent, spike_threshold);
        far_older  = far_apart(item.raw_angle, older,  spike_threshold);

        q_push            = push && !qstat.full;
        q_job.is_write    = (item.mode == MODE_WRITE);
        q_job.spike       = far_recent && far_older;
        q_job.raw_angle   = item.raw_angle;
        q_job.table_index = item.table_index;
        q_job.table_value = item.table_value;

        prev_next      = prev_reg;
        prev_prev_next = prev_prev_reg;
        primed_next    = primed_reg;
        if (q_push && (item.mode == MODE_SAMPLE))
        begin
            prev_prev_next = recent;
            prev_next      = item.raw_angle;
            primed_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            prev_prev_reg <= '0;
            primed_reg    <= 1'b0;
        end
        else
        begin
            prev_reg      <= prev_next;
            prev_prev_reg <= prev_prev_next;
            primed_reg    <= primed_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/elin_queue.sv
// Short job queue decoupling the front end from the back end.
// Depends on elin_pkg.
`default_nettype none

module elin_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   q_push,
    input  elin_pkg::elin_job_t   q_job,
    input  wire                   q_pop,
    output elin_pkg::elin_qstat_t qstat,
    output elin_pkg::elin_job_t   head
);
    import elin_pkg::*;

    elin_job_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg,  count_next;
    logic                   do_push, do_pop;

    function automatic logic [QUEUE_PTR_W-1:0] bump(input logic [QUEUE_PTR_W-1:0] p);
        begin
            bump = (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
        end
    endfunction

    always_comb
    begin
        qstat.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
        qstat.empty = (count_reg == '0);
        head        = entry_reg[rd_ptr_reg];
        do_push     = q_push && !qstat.full;
        do_pop      = q_pop && !qstat.empty;
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= q_job;
    end

endmodule

`default_nettype wire

// File: rtl/elin_back.sv
// Back end: correction table, interpolation sequencer and result register.
// Depends on elin_pkg; fed by elin_queue.
`default_nettype none

module elin_back #(
    parameter int LUT_DEPTH = 256
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  [elin_pkg::LUT_SIZE_W-1:0]  lut_size,
    input  elin_pkg::elin_qstat_t            qstat,
    input  elin_pkg::elin_job_t              head,
    output logic                             q_pop,
    input  wire                              pop,
    output logic                             empty,
    output elin_pkg::elin_out_t              result
);
    import elin_pkg::*;

    localparam int AW    = $clog2(LUT_DEPTH + 1);
    localparam int POS_W = ANGLE_W + AW;

    elin_back_state_t state_reg, state_next;

    logic [ANGLE_W-1:0] table_mem [LUT_DEPTH + 1];

    logic [POS_W-1:0]   pos_reg,     pos_next;
    logic [ANGLE_W-1:0] a_reg, b_reg;
    logic [ANGLE_W-1:0] step_reg,    step_next;
    logic [ANGLE_W-1:0] held_reg,    held_next;
    logic               out_valid_reg, out_valid_next;
    elin_out_t          out_reg,     out_next;

    logic [AW-1:0]      n_eff;
    logic [AW-1:0]      rd_idx, rd_idx_p1;
    logic               mem_we;
    logic               out_free, out_load;
    logic [ANGLE_W-1:0]          diff_u;
    logic signed [ANGLE_W:0]     diff_s, frac_s;
    logic signed [2*ANGLE_W+1:0] prod;

    always_comb
    begin
        if (lut_size == '0)
            n_eff = AW'(1);
        else if (32'(lut_size) > LUT_DEPTH)
            n_eff = AW'(LUT_DEPTH);
        else
            n_eff = AW'(lut_size);
    end

    assign rd_idx    = pos_reg[ANGLE_W +: AW];
    assign rd_idx_p1 = rd_idx + AW'(1);

    // entry difference taken modulo a revolution, then signed
    assign diff_u = b_reg - a_reg;
    assign diff_s = $signed({diff_u[ANGLE_W-1], diff_u});
    always_comb
    begin
        frac_s = $signed({1'b0, pos_reg[ANGLE_W-1:0]});
        prod   = diff_s * frac_s;
    end

    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        step_next  = step_reg;
        held_next  = held_reg;
        out_next   = out_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        out_load   = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    if (head.is_write)
                    begin
                        q_pop  = 1'b1;
                        mem_we = (32'(head.table_index) <= LUT_DEPTH);
                    end
                    else if (head.spike)
                    begin
                        if (out_free)
                        begin
                            q_pop    = 1'b1;
                            out_load = 1'b1;
                            out_next.calibrated_angle = held_reg;
                            out_next.spike_rejected   = 1'b1;
                        end
                    end
                    else
                    begin
                        q_pop      = 1'b1;
                        pos_next   = POS_W'(head.raw_angle) * POS_W'(n_eff);
                        state_next = BK_READ;
                    end
                end
            end
            BK_READ:
                state_next = BK_PROD;
            BK_PROD:
            begin
                // floor of product / 65536, modulo a revolution
                step_next  = prod[2*ANGLE_W-1:ANGLE_W];
                state_next = BK_SUM;
            end
            BK_SUM:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    held_next = a_reg + step_reg;
                    out_next.calibrated_angle = a_reg + step_reg;
                    out_next.spike_rejected   = 1'b0;
                    state_next = BK_IDLE;
                end
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        step_reg <= step_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[AW'(head.table_index)] <= head.table_value;
        if (state_reg == BK_READ)
        begin
            a_reg <= table_mem[rd_idx];
            b_reg <= table_mem[rd_idx_p1];
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == BK_IDLE) && !qstat.empty)
        else $error("job taken outside idle or from an empty queue");

    a_sum_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SUM) && !out_free |=> (state_reg == BK_SUM))
        else $error("interpolated result dropped while output busy");

    a_held_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SUM) && out_free |=>
            out_valid_reg && (held_reg == out_reg.calibrated_angle)
            && !out_reg.spike_rejected)
        else $error("held angle differs from last interpolated result");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ) |-> (32'(rd_idx) < LUT_DEPTH))
        else $error("table index beyond the last interval");

endmodule

`default_nettype wire

// File: rtl/encoder_lut_linearizer.sv
// Top level of the encoder LUT linearizer: config registers and wiring.
// Depends on elin_pkg, elin_front, elin_queue and elin_back.
//
//  Port group        Direction  Transfer when
//  item / push,full  in         push && !full
//  result / pop,empty out       pop && !empty
//  cfg_*             in         cfg_write (index 0 lut_size, 1 spike_threshold)
//
// A table write or a rejected sample is taken in the idle state; an
// interpolated sample steps through multiply, table read, product, sum.
// The front end takes an item per cycle while the 2-entry job queue is not
// full, so input and output stall independently; the result register
// holds one result. Reset clears history, held angle and control; the
// table is not cleared and must be written before use, wrap entry included.
`default_nettype none

module encoder_lut_linearizer #(
    parameter int LUT_DEPTH = 256
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               push,
    output logic                              full,
    input  elin_pkg::elin_in_t                item,
    input  wire                               pop,
    output logic                              empty,
    output elin_pkg::elin_out_t               result,
    input  wire                               cfg_write,
    input  elin_pkg::elin_cfg_index_t         cfg_index,
    input  wire  [elin_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import elin_pkg::*;

    logic [LUT_SIZE_W-1:0]  lut_size_reg,  lut_size_next;
    logic [THRESHOLD_W-1:0] threshold_reg, threshold_next;

    elin_qstat_t qstat;
    elin_job_t   q_job, head;
    logic        q_push, q_pop;

    always_comb
    begin
        lut_size_next  = lut_size_reg;
        threshold_next = threshold_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LUT_SIZE:        lut_size_next  = cfg_data[LUT_SIZE_W-1:0];
                CFG_SPIKE_THRESHOLD: threshold_next = cfg_data[THRESHOLD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lut_size_reg  <= LUT_SIZE_RESET;
            threshold_reg <= SPIKE_THRESHOLD_RESET;
        end
        else
        begin
            lut_size_reg  <= lut_size_next;
            threshold_reg <= threshold_next;
        end
    end

    assign full = qstat.full;

    elin_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .item            (item),
        .spike_threshold (threshold_reg),
        .qstat           (qstat),
        .q_push          (q_push),
        .q_job           (q_job)
    );

    elin_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_job  (q_job),
        .q_pop  (q_pop),
        .qstat  (qstat),
        .head   (head)
    );

    elin_back #(
        .LUT_DEPTH (LUT_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .lut_size (lut_size_reg),
        .qstat    (qstat),
        .head     (head),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

`default_nettype wire
